>>> sv/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// Types, codes and the 5x7 glyph table shared by the display text and fill
// engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET = 1'd1;

  localparam logic [7:0] COL_OFFSET_RST = 8'd26;
  localparam logic [7:0] ROW_OFFSET_RST = 8'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [7:0]  char_code;
    logic [1:0]  text_scale;
    logic [15:0] fore_colour;
    logic [15:0] back_colour;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] link_byte;
    logic       is_data;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_regs_t;

  // glyph columns, column 0 in the top bits
  function automatic logic [34:0] font_glyph(input logic [6:0] g);
    logic [34:0] v;
    case (g)
      7'd0:  v = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      7'd1:  v = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      7'd2:  v = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
      7'd3:  v = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
      7'd4:  v = {7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
      7'd5:  v = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
      7'd6:  v = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
      7'd7:  v = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
      7'd8:  v = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
      7'd9:  v = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
      7'd10: v = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
      7'd11: v = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
      7'd12: v = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
      7'd13: v = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      7'd14: v = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      7'd15: v = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      7'd16: v = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      7'd17: v = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      7'd18: v = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      7'd19: v = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      7'd20: v = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      7'd21: v = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      7'd22: v = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      7'd23: v = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      7'd24: v = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd25: v = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      7'd26: v = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      7'd27: v = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
      7'd28: v = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
      7'd29: v = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
      7'd30: v = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
      7'd31: v = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
      7'd32: v = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
      7'd33: v = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      7'd34: v = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd35: v = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      7'd36: v = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      7'd37: v = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      7'd38: v = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      7'd39: v = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      7'd40: v = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      7'd41: v = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      7'd42: v = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      7'd43: v = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      7'd44: v = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd45: v = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      7'd46: v = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      7'd47: v = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      7'd48: v = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      7'd49: v = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      7'd50: v = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      7'd51: v = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      7'd52: v = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      7'd53: v = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      7'd54: v = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      7'd55: v = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
      7'd56: v = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      7'd57: v = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      7'd58: v = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      7'd59: v = {7'h00, 7'h7F, 7'h41, 7'h41, 7'h00};
      7'd60: v = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
      7'd61: v = {7'h00, 7'h41, 7'h41, 7'h7F, 7'h00};
      7'd62: v = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
      7'd63: v = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd64: v = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
      7'd65: v = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
      7'd66: v = {7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
      7'd67: v = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
      7'd68: v = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
      7'd69: v = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
      7'd70: v = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
      7'd71: v = {7'h0C, 7'h52, 7'h52, 7'h52, 7'h3E};
      7'd72: v = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd73: v = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
      7'd74: v = {7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
      7'd75: v = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
      7'd76: v = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
      7'd77: v = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
      7'd78: v = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd79: v = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
      7'd80: v = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
      7'd81: v = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
      7'd82: v = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
      7'd83: v = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
      7'd84: v = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
      7'd85: v = {7'h3C, 7'h40, 7'h40, 7'h40, 7'h3C};
      7'd86: v = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
      7'd87: v = {7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C};
      7'd88: v = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
      7'd89: v = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
      7'd90: v = {7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
      7'd91: v = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
      7'd92: v = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
      7'd93: v = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
      7'd94: v = {7'h10, 7'h08, 7'h08, 7'h10, 7'h08};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/dtf_core.sv
// ----------------------------------------------------------------------------
// dtf_core
// Draw engine state: request checks, window header sequencer, pixel and
// glyph counters. Produces one result per accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_core
  import dtf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 160
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  req,
  input  wire cfg_regs_t cfg,
  output out_item_t      res,
  output logic           busy
);

  localparam logic [8:0] SW9 = 9'(SCREEN_WIDTH);
  localparam logic [8:0] SH9 = 9'(SCREEN_HEIGHT);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_CHAR = 2'd2;

  localparam logic [3:0] HDR_CASET = 4'd0;
  localparam logic [3:0] HDR_XS    = 4'd2;
  localparam logic [3:0] HDR_XE    = 4'd4;
  localparam logic [3:0] HDR_RASET = 4'd5;
  localparam logic [3:0] HDR_YS    = 4'd7;
  localparam logic [3:0] HDR_YE    = 4'd9;
  localparam logic [3:0] HDR_RAMWR = 4'd10;
  localparam logic [3:0] HDR_LEN   = 4'd11;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic [2:0] GW_LAST = 3'(GLYPH_WIDTH - 1);

  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  hdr_r, hdr_nxt;
  logic [7:0]  x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic [15:0] pix_left_r, pix_left_nxt;
  logic [2:0]  gl_row_r, gl_row_nxt, gl_col_r, gl_col_nxt;
  logic [1:0]  gl_rowrep_r, gl_rowrep_nxt, gl_colrep_r, gl_colrep_nxt;
  logic        low_half_r, low_half_nxt;
  logic [15:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic [6:0]  glyph_r, glyph_nxt;
  logic [1:0]  scale_r, scale_nxt;

  // request checks
  logic [8:0]  x9, y9, xw, yh;
  logic [7:0]  w_clip, h_clip;
  logic        fill_ok, char_ok;
  logic [1:0]  s;
  logic [7:0]  code;
  logic [3:0]  cw;
  logic [4:0]  ch;
  logic [15:0] fill_cnt, char_cnt;

  // pixel path
  logic [34:0] glyph_bits;
  logic [6:0]  col_bits;
  logic [7:0]  col_ext;
  logic [15:0] colour;
  logic [7:0]  hdr_byte;
  logic        hdr_data;
  logic [15:0] pix_dec;

  always_comb begin
    x9 = {1'b0, req.x_pos};
    y9 = {1'b0, req.y_pos};
    xw = x9 + {1'b0, req.rect_width};
    yh = y9 + {1'b0, req.rect_height};
    w_clip = (xw > SW9) ? 8'(SW9 - x9) : req.rect_width;
    h_clip = (yh > SH9) ? 8'(SH9 - y9) : req.rect_height;
    fill_ok = (x9 < SW9) && (y9 < SH9) && (w_clip != 8'd0) && (h_clip != 8'd0);
    fill_cnt = w_clip * h_clip;

    s = (req.text_scale == 2'd0) ? 2'd1 : req.text_scale;
    code = ((req.char_code < CHAR_FIRST) || (req.char_code > CHAR_LAST)) ?
           CHAR_QMARK : req.char_code;
    cw = 4'(GLYPH_WIDTH) * {2'b0, s};
    ch = 5'(GLYPH_HEIGHT) * {3'b0, s};
    char_ok = ((x9 + {5'b0, cw}) <= SW9) && ((y9 + {4'b0, ch}) <= SH9);
    char_cnt = 16'(cw) * 16'(ch);
  end

  always_comb begin
    hdr_data = 1'b1;
    case (hdr_r)
      HDR_CASET: begin
        hdr_byte = CMD_CASET;
        hdr_data = 1'b0;
      end
      HDR_XS:    hdr_byte = x0_r + cfg.column_offset;
      HDR_XE:    hdr_byte = x1_r + cfg.column_offset;
      HDR_RASET: begin
        hdr_byte = CMD_RASET;
        hdr_data = 1'b0;
      end
      HDR_YS:    hdr_byte = y0_r + cfg.row_offset;
      HDR_YE:    hdr_byte = y1_r + cfg.row_offset;
      HDR_RAMWR: begin
        hdr_byte = CMD_RAMWR;
        hdr_data = 1'b0;
      end
      default:   hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    glyph_bits = font_glyph(glyph_r);
    case (gl_col_r)
      3'd0:    col_bits = glyph_bits[34:28];
      3'd1:    col_bits = glyph_bits[27:21];
      3'd2:    col_bits = glyph_bits[20:14];
      3'd3:    col_bits = glyph_bits[13:7];
      3'd4:    col_bits = glyph_bits[6:0];
      default: col_bits = 7'h00;
    endcase
    col_ext = {1'b0, col_bits};
    colour = fg_r;
    if ((mode_r == MODE_CHAR) && !col_ext[gl_row_r]) begin
      colour = bg_r;
    end
    pix_dec = (pix_left_r != 16'd0) ? pix_left_r - 16'd1 : 16'd0;
  end

  always_comb begin
    mode_nxt      = mode_r;
    hdr_nxt       = hdr_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    pix_left_nxt  = pix_left_r;
    gl_row_nxt    = gl_row_r;
    gl_col_nxt    = gl_col_r;
    gl_rowrep_nxt = gl_rowrep_r;
    gl_colrep_nxt = gl_colrep_r;
    low_half_nxt  = low_half_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    glyph_nxt     = glyph_r;
    scale_nxt     = scale_r;
    res           = '{kind: KIND_IDLE, link_byte: 8'h00, is_data: 1'b0, last_byte: 1'b0};

    if (fire) begin
      case (req.op)
        OP_FILL, OP_CHAR: begin
          res.kind = KIND_REJECT;
          if ((mode_r == MODE_IDLE) &&
              (((req.op == OP_FILL) && fill_ok) || ((req.op == OP_CHAR) && char_ok))) begin
            res.kind      = KIND_ACCEPT;
            hdr_nxt       = 4'd0;
            x0_nxt        = req.x_pos;
            y0_nxt        = req.y_pos;
            gl_row_nxt    = 3'd0;
            gl_col_nxt    = 3'd0;
            gl_rowrep_nxt = 2'd0;
            gl_colrep_nxt = 2'd0;
            low_half_nxt  = 1'b0;
            fg_nxt        = req.fore_colour;
            if (req.op == OP_FILL) begin
              mode_nxt     = MODE_FILL;
              x1_nxt       = req.x_pos + w_clip - 8'd1;
              y1_nxt       = req.y_pos + h_clip - 8'd1;
              pix_left_nxt = fill_cnt;
            end else begin
              mode_nxt     = MODE_CHAR;
              x1_nxt       = req.x_pos + {4'b0, cw} - 8'd1;
              y1_nxt       = req.y_pos + {3'b0, ch} - 8'd1;
              pix_left_nxt = char_cnt;
              bg_nxt       = req.back_colour;
              glyph_nxt    = 7'(code - CHAR_FIRST);
              scale_nxt    = s;
            end
          end
        end
        OP_STEP: begin
          if (mode_r != MODE_IDLE) begin
            res.kind = KIND_BYTE;
            if (hdr_r < HDR_LEN) begin
              res.link_byte = hdr_byte;
              res.is_data   = hdr_data;
              hdr_nxt       = hdr_r + 4'd1;
            end else begin
              res.is_data = 1'b1;
              if (!low_half_r) begin
                res.link_byte = colour[15:8];
                low_half_nxt  = 1'b1;
              end else begin
                res.link_byte = colour[7:0];
                low_half_nxt  = 1'b0;
                if (mode_r == MODE_CHAR) begin
                  if ({1'b0, gl_colrep_r} + 3'd1 >= {1'b0, scale_r}) begin
                    gl_colrep_nxt = 2'd0;
                    if (gl_col_r >= GW_LAST) begin
                      gl_col_nxt = 3'd0;
                      if ({1'b0, gl_rowrep_r} + 3'd1 >= {1'b0, scale_r}) begin
                        gl_rowrep_nxt = 2'd0;
                        gl_row_nxt    = gl_row_r + 3'd1;
                      end else begin
                        gl_rowrep_nxt = gl_rowrep_r + 2'd1;
                      end
                    end else begin
                      gl_col_nxt = gl_col_r + 3'd1;
                    end
                  end else begin
                    gl_colrep_nxt = gl_colrep_r + 2'd1;
                  end
                end
                pix_left_nxt = pix_dec;
                if (pix_dec == 16'd0) begin
                  res.last_byte = 1'b1;
                  mode_nxt      = MODE_IDLE;
                  hdr_nxt       = 4'd0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      hdr_r       <= 4'd0;
      pix_left_r  <= 16'd0;
      gl_row_r    <= 3'd0;
      gl_col_r    <= 3'd0;
      gl_rowrep_r <= 2'd0;
      gl_colrep_r <= 2'd0;
      low_half_r  <= 1'b0;
      scale_r     <= 2'd0;
    end else begin
      mode_r      <= mode_nxt;
      hdr_r       <= hdr_nxt;
      pix_left_r  <= pix_left_nxt;
      gl_row_r    <= gl_row_nxt;
      gl_col_r    <= gl_col_nxt;
      gl_rowrep_r <= gl_rowrep_nxt;
      gl_colrep_r <= gl_colrep_nxt;
      low_half_r  <= low_half_nxt;
      scale_r     <= scale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r    <= x0_nxt;
    y0_r    <= y0_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    fg_r    <= fg_nxt;
    bg_r    <= bg_nxt;
    glyph_r <= glyph_nxt;
  end

  assign busy = (mode_r != MODE_IDLE);

endmodule

`default_nettype wire

>>> sv/display_text_and_fill_engine.sv
// ----------------------------------------------------------------------------
// display_text_and_fill_engine
// Link byte generator for a serial TFT panel: rectangle fills and scaled 5x7
// characters, window header then RGB565 pixels, one byte per step request while busy.
//
//   channel  ports                              direction
//   in       in_valid, in_ready, in_data        draw or step requests
//   out      out_valid, out_ready, out_data     one result per request
//   cfg      cfg_valid, cfg_ready, cfg_index,   panel column and row offsets
//            cfg_data
//
// one request per cycle unless out_ready stalls; its result appears in the
// output register in the cycle after acceptance.
// the output register is the only stage: a new request is taken whenever the
// register is empty or being drained in the same cycle.
// reset (rst_n low, synchronous) leaves the engine idle, offsets 26 and 1.
// cfg writes are never stalled; each is registered as it is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module display_text_and_fill_engine
  import dtf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 160
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic      fire;
  logic      busy;
  out_item_t res;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  cfg_regs_t cfg_r, cfg_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  dtf_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (in_data),
    .cfg  (cfg_r),
    .res  (res),
    .busy (busy)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_COL_OFFSET: cfg_nxt.column_offset = cfg_data;
        CFG_ROW_OFFSET: cfg_nxt.row_offset    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cfg_r       <= '{column_offset: COL_OFFSET_RST, row_offset: ROW_OFFSET_RST};
    end else begin
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_byte |->
      (out_data_r.kind == KIND_BYTE) && out_data_r.is_data)
    else $error("last flag on a non pixel result");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.kind != KIND_BYTE) |->
      (out_data_r.link_byte == 8'h00) && !out_data_r.is_data)
    else $error("byte fields set on a non byte result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.kind == KIND_ACCEPT) |=> busy)
    else $error("engine idle after an accepted request");

  a_byte_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.kind == KIND_BYTE) |-> busy)
    else $error("link byte produced while idle");

endmodule

`default_nettype wire
